// ----- rtl/rbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types, codes and sizes of the reference-counted block pool.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int COUNT_BITS = 8;

    // Index into the count store and width of a value that can hold NUM_BLOCKS.
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    // Width used for pool size compares; covers the 5-bit register as well.
    localparam int SZ_W  = (CNT_W > 5) ? CNT_W : 5;

    // Configuration registers.
    localparam int                CFG_IDX_W         = 2;
    localparam int                CFG_DATA_W        = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_CLOSED   = 2'd1;
    localparam logic [4:0]        ACTIVE_RESET      = 5'd16;

    // Request functions.
    localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [1:0] FUNC_RETAIN  = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Response status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NONE_FREE = 3'd1;
    localparam logic [2:0] ST_CLOSED    = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_SATURATED = 3'd4;

    // Shared unit operations.
    localparam logic ALU_INC = 1'b0;
    localparam logic ALU_DEC = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] block_index;
    } in_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] granted_index;
        logic [7:0] count_after;
        logic       became_free;
    } out_rsp_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        count_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } store_req_t;

    typedef struct packed {
        count_t result;
        logic   is_zero;
        logic   is_max;
        logic   res_zero;
    } alu_rsp_t;

    // Low 8 bits of a count, zero-extended when the count is narrower.
    function automatic logic [7:0] count_to_field(input count_t c);
        logic [COUNT_BITS+7:0] w;
        w = {8'd0, c};
        return w[7:0];
    endfunction

endpackage : rbp_pkg
`default_nettype wire

// ----- rtl/refcounted_block_pool_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_block_pool_top
// Reference-counted pool of fixed blocks with acquire, retain and release.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on in_valid/in_stall with in_data (func, block_index) and
// is taken at an edge where in_valid is high and in_stall is low. Every
// request produces exactly one response on out_valid/out_stall with out_data
// (status, granted_index, count_after, became_free).
// A retain or release passes through the execute and response states, and a
// rejected request goes straight to the response state. An acquire scans
// the count store one block per cycle through the single shared count unit,
// lowest index first, and stops at the first free block or after the last
// active block.
// The block works on one request at a time: in_stall stays high from the
// accept until the response has moved into the output register, so it
// takes no new request before it is through with the last.
// A stalled response holds in the output register; the next request may be
// accepted meanwhile, but its own response waits for the register to drain.
// Reset clears all reference counts at once (they sit in flip-flops), sets
// active_blocks to 16 and opens the pool. Configuration writes on
// cfg_write_en/cfg_index/cfg_data take effect at the next edge.
// ----------------------------------------------------------------------------
module refcounted_block_pool_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [rbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rbp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire rbp_pkg::in_req_t                  in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output rbp_pkg::out_rsp_t                      out_data
);
    import rbp_pkg::*;

    // Configuration registers.
    logic [4:0]      active_blocks_reg;
    logic            pool_closed_reg;
    logic [SZ_W-1:0] active_ext;
    logic [SZ_W-1:0] pool_size;

    // Output register.
    logic     out_valid_reg;
    out_rsp_t out_data_reg;
    logic     out_free;

    // Internal connections.
    logic       busy;
    logic       req_accept;
    logic       alu_op;
    count_t     rd_data;
    alu_rsp_t   alu_rsp;
    store_req_t store_req;
    logic       rsp_push;
    out_rsp_t   rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_blocks_reg <= ACTIVE_RESET;
            pool_closed_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ACTIVE_BLOCKS: active_blocks_reg <= cfg_data[4:0];
                CFG_POOL_CLOSED:   pool_closed_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // The pool never reaches past the blocks that are built.
    assign active_ext = SZ_W'(active_blocks_reg);
    assign pool_size  = (active_ext < SZ_W'(NUM_BLOCKS)) ? active_ext : SZ_W'(NUM_BLOCKS);

    // The output register is free when empty or when its response leaves now.
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = busy;
    assign req_accept = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_push)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rbp_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (rd_data)
    );

    rbp_alu u_alu (
        .op    (alu_op),
        .count (rd_data),
        .rsp   (alu_rsp)
    );

    rbp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_accept  (req_accept),
        .req         (in_data),
        .pool_size   (pool_size),
        .pool_closed (pool_closed_reg),
        .alu_rsp     (alu_rsp),
        .out_free    (out_free),
        .busy        (busy),
        .alu_op      (alu_op),
        .store_req   (store_req),
        .rsp_push    (rsp_push),
        .rsp         (rsp)
    );

endmodule : refcounted_block_pool_top
`default_nettype wire

// ----- rtl/rbp_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbp_store
// Reference count array: one read address, one write address per cycle.
// ----------------------------------------------------------------------------
module rbp_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rbp_pkg::store_req_t req,
    output rbp_pkg::count_t         rd_data
);
    import rbp_pkg::*;

    count_t count_reg [NUM_BLOCKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (req.wr_en)
        begin
            count_reg[req.wr_addr] <= req.wr_data;
        end
    end

    assign rd_data = count_reg[req.rd_addr];

endmodule : rbp_store
`default_nettype wire

// ----- rtl/rbp_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbp_alu
// Shared count unit: saturating increment or clamped decrement with flags.
// ----------------------------------------------------------------------------
module rbp_alu (
    input  wire logic            op,
    input  wire rbp_pkg::count_t count,
    output rbp_pkg::alu_rsp_t    rsp
);
    import rbp_pkg::*;

    logic   is_zero;
    logic   is_max;
    count_t result;

    assign is_zero = (count == '0);
    assign is_max  = (count == '1);

    always_comb
    begin
        case (op)
            ALU_INC: result = is_max ? count : count + 1'b1;
            ALU_DEC: result = is_zero ? count : count - 1'b1;
            default: result = count;
        endcase
    end

    assign rsp.result   = result;
    assign rsp.is_zero  = is_zero;
    assign rsp.is_max   = is_max;
    assign rsp.res_zero = (result == '0);

endmodule : rbp_alu
`default_nettype wire

// ----- rtl/rbp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbp_ctrl
// Sequencer: decodes a request, scans or updates the count store through the
// shared unit, and holds the response until the output register takes it.
// ----------------------------------------------------------------------------
module rbp_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_accept,
    input  wire rbp_pkg::in_req_t         req,
    input  wire logic [rbp_pkg::SZ_W-1:0] pool_size,
    input  wire logic                     pool_closed,
    input  wire rbp_pkg::alu_rsp_t        alu_rsp,
    input  wire logic                     out_free,
    output logic                          busy,
    output logic                          alu_op,
    output rbp_pkg::store_req_t           store_req,
    output logic                          rsp_push,
    output rbp_pkg::out_rsp_t             rsp
);
    import rbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RESP
    } state_t;

    state_t          state_reg;
    logic [1:0]      func_reg;
    logic [3:0]      idx_reg;
    logic [SZ_W-1:0] scan_reg;
    out_rsp_t        rsp_reg;

    logic [SZ_W-1:0] idx_ext;
    logic [SZ_W-1:0] req_idx_ext;
    logic [SZ_W-1:0] scan_next;
    out_rsp_t        start_rsp;
    state_t          start_state;

    assign idx_ext     = SZ_W'(idx_reg);
    assign req_idx_ext = SZ_W'(req.block_index);
    assign scan_next   = scan_reg + 1'b1;

    assign busy     = (state_reg != S_IDLE);
    assign rsp_push = (state_reg == S_RESP) && out_free;
    assign rsp      = rsp_reg;
    assign alu_op   = (state_reg == S_EXEC && func_reg == FUNC_RELEASE) ? ALU_DEC : ALU_INC;

    // Decode of a new request: requests that are rejected at once get their
    // whole response here and go straight to the response state.
    always_comb
    begin
        start_rsp   = '0;
        start_state = S_EXEC;
        if (req.func == FUNC_ACQUIRE)
        begin
            if (pool_closed)
            begin
                start_rsp.status = ST_CLOSED;
                start_state      = S_RESP;
            end
            else if (pool_size == '0)
            begin
                start_rsp.status = ST_NONE_FREE;
                start_state      = S_RESP;
            end
            else
            begin
                start_state = S_SCAN;
            end
        end
        else if ((req.func != FUNC_RETAIN && req.func != FUNC_RELEASE)
                 || req_idx_ext >= pool_size)
        begin
            start_rsp.status        = ST_RANGE;
            start_rsp.granted_index = req.block_index;
            start_state             = S_RESP;
        end
    end

    always_comb
    begin
        store_req.rd_addr = (state_reg == S_SCAN) ? scan_reg[IDX_W-1:0] : idx_ext[IDX_W-1:0];
        store_req.wr_addr = store_req.rd_addr;
        store_req.wr_data = alu_rsp.result;
        case (state_reg)
            S_SCAN:  store_req.wr_en = alu_rsp.is_zero;
            S_EXEC:  store_req.wr_en = (func_reg == FUNC_RETAIN) ? !alu_rsp.is_max
                                                                 : !alu_rsp.is_zero;
            default: store_req.wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= FUNC_ACQUIRE;
            idx_reg   <= '0;
            scan_reg  <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        func_reg  <= req.func;
                        idx_reg   <= req.block_index;
                        scan_reg  <= '0;
                        rsp_reg   <= start_rsp;
                        state_reg <= start_state;
                    end
                end
                S_SCAN:
                begin
                    if (alu_rsp.is_zero)
                    begin
                        rsp_reg.status        <= ST_OK;
                        rsp_reg.granted_index <= scan_reg[3:0];
                        rsp_reg.count_after   <= count_to_field(alu_rsp.result);
                        state_reg             <= S_RESP;
                    end
                    else if (scan_next == pool_size)
                    begin
                        rsp_reg.status <= ST_NONE_FREE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        scan_reg <= scan_next;
                    end
                end
                S_EXEC:
                begin
                    rsp_reg.granted_index <= idx_reg;
                    rsp_reg.count_after   <= count_to_field(alu_rsp.result);
                    if (func_reg == FUNC_RETAIN)
                    begin
                        rsp_reg.status <= alu_rsp.is_max ? ST_SATURATED : ST_OK;
                    end
                    else
                    begin
                        rsp_reg.status      <= ST_OK;
                        rsp_reg.became_free <= !alu_rsp.is_zero && alu_rsp.res_zero;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule : rbp_ctrl
`default_nettype wire

// ----- verif/refcounted_block_pool_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_block_pool_checker
// Watches the request, response and register ports of the block pool, keeps
// its own copy of the reference counts and the pool settings, and compares
// every response field by field with the one predicted for the request.
// ----------------------------------------------------------------------------
module refcounted_block_pool_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [rbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rbp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire rbp_pkg::in_req_t                  in_data,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire rbp_pkg::out_rsp_t                 out_data,
    output int                                     mismatches,
    output int                                     outstanding
);

    import rbp_pkg::*;

    logic [COUNT_BITS-1:0] block_refs [NUM_BLOCKS];
    logic [4:0]            active_setting;
    logic                  closed_setting;
    out_rsp_t              pending_rsps [$];

    // Applies one request to the shadow counts and returns the response it
    // must produce.
    function automatic out_rsp_t apply_request(input in_req_t req);
        out_rsp_t    rsp;
        int unsigned reach;
        bit          found;
        rsp   = '0;
        found = 1'b0;
        reach = (active_setting < NUM_BLOCKS) ? active_setting : NUM_BLOCKS;
        if (req.func == FUNC_ACQUIRE) begin
            if (closed_setting) begin
                rsp.status = ST_CLOSED;
            end
            else begin
                rsp.status = ST_NONE_FREE;
                for (int b = 0; b < reach; b++) begin
                    if (!found && block_refs[b] == '0) begin
                        found               = 1'b1;
                        block_refs[b]       = COUNT_BITS'(1);
                        rsp.status          = ST_OK;
                        rsp.granted_index   = 4'(b);
                        rsp.count_after     = 8'd1;
                    end
                end
            end
        end
        else if ((req.func != FUNC_RETAIN && req.func != FUNC_RELEASE)
                 || req.block_index >= reach) begin
            rsp.status        = ST_RANGE;
            rsp.granted_index = req.block_index;
        end
        else begin
            rsp.status        = ST_OK;
            rsp.granted_index = req.block_index;
            if (req.func == FUNC_RETAIN) begin
                if (block_refs[req.block_index] == '1)
                    rsp.status = ST_SATURATED;
                else
                    block_refs[req.block_index] = block_refs[req.block_index] + 1'b1;
            end
            else if (block_refs[req.block_index] != '0) begin
                block_refs[req.block_index] = block_refs[req.block_index] - 1'b1;
                rsp.became_free = (block_refs[req.block_index] == '0);
            end
            rsp.count_after = block_refs[req.block_index];
        end
        return rsp;
    endfunction

    always @(posedge clk) begin : watch
        out_rsp_t want;
        if (!rst_n) begin
            for (int b = 0; b < NUM_BLOCKS; b++)
                block_refs[b] = '0;
            active_setting = ACTIVE_RESET;
            closed_setting = 1'b0;
            pending_rsps.delete();
            mismatches     = 0;
            outstanding   <= 0;
        end
        else begin
            // Responses are checked before requests are predicted, so a
            // response never meets the expectation of a request taken at the
            // same edge.
            if (out_valid && !out_stall) begin
                if (pending_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response status=%0d index=%0d count=%0d freed=%0d",
                                 $realtime, out_data.status, out_data.granted_index,
                                 out_data.count_after, out_data.became_free);
                end
                else begin
                    want = pending_rsps.pop_front();
                    if (out_data.status !== want.status
                        || out_data.granted_index !== want.granted_index
                        || out_data.count_after !== want.count_after
                        || out_data.became_free !== want.became_free) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: response mismatch: expected status=%0d index=%0d ",
                                      "count=%0d freed=%0d, got status=%0d index=%0d ",
                                      "count=%0d freed=%0d"},
                                     $realtime, want.status, want.granted_index,
                                     want.count_after, want.became_free, out_data.status,
                                     out_data.granted_index, out_data.count_after,
                                     out_data.became_free);
                    end
                end
            end
            if (cfg_write_en) begin
                if (cfg_index == CFG_ACTIVE_BLOCKS)
                    active_setting = cfg_data[4:0];
                else if (cfg_index == CFG_POOL_CLOSED)
                    closed_setting = cfg_data[0];
            end
            if (in_valid && !in_stall)
                pending_rsps.push_back(apply_request(in_data));
            outstanding <= pending_rsps.size();
        end
    end

endmodule : refcounted_block_pool_checker
`default_nettype wire

// ----- verif/refcounted_block_pool_top_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_block_pool_top_tb
// Drives acquire, retain, release and undefined requests into the block pool
// under changing pool sizes and open/closed settings, with random gaps and
// stalls, and leaves the checking of responses to the checker beside the block.
// ----------------------------------------------------------------------------
module refcounted_block_pool_top_tb;

    import rbp_pkg::*;

    // The function code that the block does not define, and the two register
    // indexes that hold no register. Both must be answered or ignored cleanly.
    localparam logic [1:0]           FUNC_UNDEFINED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 2'd3;

    localparam int TOTAL_REQUESTS = 1950;
    // Extra waits once the block has gone quiet, and before the run ends.
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 3 * (NUM_BLOCKS + 2);
    // Length of the one long stall of the response side.
    localparam int LONG_HOLD      = 300;
    // Cycles without any handshake after which the run is declared hung.
    localparam int QUIET_LIMIT    = 2000;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    in_req_t               in_data      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    out_rsp_t              out_data;

    int mismatches;
    int outstanding;

    // Knobs shared between the request side and the response side.
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_outputs   = 1'b0;

    int requests_sent = 0;
    // Number of blocks the pool currently uses, as the stimulus sees it.
    int pool_size     = NUM_BLOCKS;
    int quiet_cycles  = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    refcounted_block_pool_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    refcounted_block_pool_checker pool_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Hang detection: any request, response or register write restarts the
    // count. The long stall of the response side stays far below the limit.
    always @(posedge clk) begin
        if (!rst_n || cfg_write_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Response side. Before each response it draws a random stall
    // while idling is on, then takes the response. Once, on request of the
    // stimulus, it holds off for a long stretch so that the block backs up
    // and stalls its request port.
    initial begin : response_side
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_outputs) begin
                hold_outputs = 1'b0;
                out_stall   <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = receiver_idles ? $urandom_range(0, 9) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offers one request after a random gap and returns at the edge where it
    // is taken. Valid is left high so that a back-to-back request never
    // lowers and raises it in the same step.
    task automatic send_request(input logic [1:0] func, input logic [3:0] index);
        int      gap;
        in_req_t req;
        gap             = sender_idles ? $urandom_range(0, 9) : 0;
        req.func        = func;
        req.block_index = index;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted response has come out.
    // The checker's count is registered, hence the first edge before looking.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        if (index == CFG_ACTIVE_BLOCKS)
            pool_size = (value > NUM_BLOCKS) ? NUM_BLOCKS : int'(value);
    endtask

    // Registers are only written once the block has gone quiet. Only bit 0 of
    // closed_word counts; the upper bits check that the block masks them.
    task automatic configure(input logic [4:0] active, input logic [CFG_DATA_W-1:0] closed_word);
        wait_idle();
        write_register(CFG_ACTIVE_BLOCKS, active);
        write_register(CFG_POOL_CLOSED, closed_word);
    endtask

    // Mostly an index inside the pool, sometimes any index at all.
    function automatic logic [3:0] pick_index();
        if (pool_size > 0 && $urandom_range(0, 99) < 85)
            return 4'($urandom_range(0, pool_size - 1));
        return 4'($urandom);
    endfunction

    function automatic logic [1:0] pick_func();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return FUNC_ACQUIRE;
        if (pick < 68)
            return FUNC_RETAIN;
        if (pick < 95)
            return FUNC_RELEASE;
        return FUNC_UNDEFINED;
    endfunction

    // One random stretch of traffic. Besides plain mixed traffic, it fills
    // the pool past its size so that acquires run dry and then frees every
    // block once, or retains one block n times and releases it n + 1 times.
    task automatic run_sequence();
        int kind;
        int n;
        int b;
        logic [3:0] target;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            n = $urandom_range(4, 16);
            repeat (n) send_request(pick_func(), pick_index());
        end
        else if (kind < 75) begin
            repeat (pool_size + 2) send_request(FUNC_ACQUIRE, 4'($urandom));
            for (b = 0; b < pool_size; b++)
                send_request(FUNC_RELEASE, 4'(b));
        end
        else begin
            target = pick_index();
            n      = $urandom_range(1, 6);
            repeat (n) send_request(FUNC_RETAIN, target);
            repeat (n + 1) send_request(FUNC_RELEASE, target);
        end
    endtask

    initial begin : stimulus
        int         phase;
        int         phase_goal;
        int         midpoint;
        bit         paused;
        logic [3:0] target;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a fresh pool of all sixteen blocks.
        // Two acquires take blocks 0 and 1; the index of an acquire is ignored.
        send_request(FUNC_ACQUIRE, 4'd0);
        send_request(FUNC_ACQUIRE, 4'd15);
        send_request(FUNC_RETAIN, 4'd0);
        // Block 1 drops to zero, then a release of an already free block.
        send_request(FUNC_RELEASE, 4'd1);
        send_request(FUNC_RELEASE, 4'd1);
        // A retain of a free block takes it from zero to one.
        send_request(FUNC_RETAIN, 4'd15);
        send_request(FUNC_RELEASE, 4'd15);
        send_request(FUNC_UNDEFINED, 4'd15);
        send_request(FUNC_UNDEFINED, 4'd0);

        // An empty pool: nothing to grant, every index is out of range.
        configure(5'd0, 5'd0);
        send_request(FUNC_ACQUIRE, 4'd0);
        send_request(FUNC_RETAIN, 4'd0);
        send_request(FUNC_RELEASE, 4'd15);

        // A size above the number of blocks is clipped to all of them.
        configure(5'd31, 5'd0);
        send_request(FUNC_RETAIN, 4'd15);
        send_request(FUNC_RELEASE, 4'd15);

        // Shrunk to one busy block: acquire finds nothing free and block 1
        // keeps its count but cannot be reached.
        configure(5'd1, 5'd0);
        send_request(FUNC_ACQUIRE, 4'd0);
        send_request(FUNC_RELEASE, 4'd1);
        send_request(FUNC_RETAIN, 4'd0);

        // Closed pool with all data bits set: acquire fails, counts still move.
        configure(5'd1, 5'h1F);
        send_request(FUNC_ACQUIRE, 4'd0);
        send_request(FUNC_RETAIN, 4'd0);
        send_request(FUNC_RELEASE, 4'd0);

        // Writes to the spare indexes must change nothing. Then the pool is
        // reopened by a word whose bit 0 is clear but whose other bits are set.
        wait_idle();
        write_register(CFG_SPARE_LO, 5'h1F);
        write_register(CFG_SPARE_HI, 5'h00);
        configure(5'd16, 5'h1E);
        send_request(FUNC_ACQUIRE, 4'd0);

        // Random part, in phases with their own pool settings and idling.
        // The first phases cover the extreme sizes, one phase drives a block
        // into saturation and back, and one backs up the whole block.
        phase = 0;
        while (requests_sent < TOTAL_REQUESTS) begin
            sender_idles   = (phase % 3) != 2;
            receiver_idles = (phase % 4) != 3;
            case (phase)
                0: configure(5'd16, 5'd0);
                1: configure(5'd1, 5'(2 * $urandom_range(0, 15)));
                2: configure(5'd0, 5'd0);
                3: configure(5'd31, 5'd1);
                4, 5: configure(5'd16, 5'd0);
                default: configure(5'($urandom_range(0, 31)),
                                   5'({$urandom_range(0, 15), $urandom_range(0, 4) == 0}));
            endcase

            if (phase == 4) begin
                // Enough retains to saturate any block from any count, then
                // enough releases to bring it to zero and past it.
                target = 4'($urandom);
                repeat ((1 << COUNT_BITS) + 2) send_request(FUNC_RETAIN, target);
                repeat ((1 << COUNT_BITS) + 4) send_request(FUNC_RELEASE, target);
            end
            else begin
                if (phase == 5) begin
                    // Back-to-back requests against a long response stall.
                    sender_idles = 1'b0;
                    hold_outputs = 1'b1;
                end
                if (phase >= 1 && phase <= 3)
                    phase_goal = $urandom_range(30, 60);
                else
                    phase_goal = $urandom_range(80, 160);
                midpoint   = requests_sent + phase_goal / 2;
                phase_goal = requests_sent + phase_goal;
                if (phase_goal > TOTAL_REQUESTS)
                    phase_goal = TOTAL_REQUESTS;
                paused     = 1'b0;
                while (requests_sent < phase_goal) begin
                    run_sequence();
                    // Halfway through, let the block run completely dry.
                    if (!paused && requests_sent >= midpoint) begin
                        wait_idle();
                        paused = 1'b1;
                    end
                end
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule : refcounted_block_pool_top_tb
`default_nettype wire

// ----- refcounted_block_pool_top.f -----
rtl/rbp_pkg.sv
rtl/rbp_store.sv
rtl/rbp_alu.sv
rtl/rbp_ctrl.sv
rtl/refcounted_block_pool_top.sv
verif/refcounted_block_pool_checker.sv
verif/refcounted_block_pool_top_tb.sv
